/* hdl/scfb_pkg.sv */
// Package with frame constants and types for the serial command frame builder.
`timescale 1ns / 1ps

package scfb_pkg;

   // Frame storage
   localparam int unsigned FRAME_MAX  = 12;
   localparam int unsigned COUNT_BITS = $clog2(FRAME_MAX + 1);

   typedef logic [7:0] frame_byte_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   // Operation codes
   localparam logic [1:0] OP_PLAIN = 2'd0;
   localparam logic [1:0] OP_VALUE = 2'd1;
   localparam logic [1:0] OP_DRIVE = 2'd2;
   localparam logic [1:0] OP_START = 2'd3;

   // Fixed frame bytes
   localparam frame_byte_type HDR0 = 8'h53;
   localparam frame_byte_type HDR1 = 8'h4B;
   localparam frame_byte_type TRL0 = 8'h0D;
   localparam frame_byte_type TRL1 = 8'h0A;

   // Length bytes as sent
   localparam frame_byte_type LEN_BYTE_PLAIN = 8'h08;
   localparam frame_byte_type LEN_BYTE_VALUE = 8'h09;
   localparam frame_byte_type LEN_BYTE_DRIVE = 8'h0C;
   localparam frame_byte_type LEN_BYTE_START = 8'h02;

   // Fixed command codes
   localparam logic [15:0] DRIVE_CMD = 16'h0018;
   localparam logic [15:0] START_CMD = 16'h0016;

   // Frame sizes in bytes
   localparam count_type SIZE_PLAIN = COUNT_BITS'(8);
   localparam count_type SIZE_VALUE = COUNT_BITS'(9);
   localparam count_type SIZE_DRIVE = COUNT_BITS'(12);
   localparam count_type SIZE_START = COUNT_BITS'(8);

endpackage

/* hdl/serial_command_frame_builder.sv */
// Top level of the serial command frame builder: request in, frame bytes out.
`timescale 1ns / 1ps

// Usage:
//   The req_ channel carries one command request per transfer (operation,
//   command, value, left_pwm, right_pwm). The rsp_ channel returns the
//   frame, one byte per transfer, with rsp_last high on the final byte.
//   Frames are 8, 9 or 12 bytes long depending on the operation.
//   The request transfer loads the frame register; the first byte of the
//   frame then moves from the frame register into the output register once
//   the output register is free. Throughput: one byte per cycle while the
//   receiver does not stall, set by the frame shift register that feeds the
//   output register one byte each cycle.
//   A new request is taken in the same cycle that the last byte of the
//   current frame moves into the output register, so frames follow each
//   other without a gap.
//   Reset clears the busy flag and the output valid; any frame in progress
//   is dropped. When the receiver stalls, the output register holds its
//   byte and the frame register holds the rest; req_ready stays low until
//   the last byte moves into the output register.
module serial_command_frame_builder (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_operation,
   input  logic [15:0]           req_command,
   input  logic [7:0]            req_value,
   input  logic signed [15:0]    req_left_pwm,
   input  logic signed [15:0]    req_right_pwm,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output scfb_pkg::frame_byte_type rsp_tx_byte,
   output logic                  rsp_last
);
   import scfb_pkg::*;

   frame_byte_type frame_ff [FRAME_MAX];
   frame_byte_type frame_in [FRAME_MAX];
   frame_byte_type built    [FRAME_MAX];
   count_type      rem_ff;
   count_type      rem_in;
   count_type      built_size;
   logic           busy_ff;
   logic           busy_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   frame_byte_type rsp_tx_byte_ff;
   logic           rsp_last_ff;
   logic           advance;
   logic           last_byte;
   logic           req_fire;
   frame_byte_type left_lo;
   frame_byte_type left_hi;
   frame_byte_type right_lo;
   frame_byte_type right_hi;

   // Handshake control
   always_comb begin
      advance   = busy_ff && (!rsp_valid_ff || rsp_ready);
      last_byte = (rem_ff == COUNT_BITS'(1));
      req_ready = !busy_ff || (advance && last_byte);
      req_fire  = req_valid && req_ready;
   end

   // Build the whole frame from the request
   always_comb begin
      left_lo  = req_left_pwm[7:0];
      left_hi  = req_left_pwm[15:8];
      right_lo = req_right_pwm[7:0];
      right_hi = req_right_pwm[15:8];
      for (int i = 0; i < FRAME_MAX; i++) begin
         built[i] = '0;
      end
      built[0] = HDR0;
      built[1] = HDR1;
      case (req_operation)
         OP_PLAIN: begin
            built[2] = LEN_BYTE_PLAIN;
            built[3] = req_command[15:8];
            built[4] = req_command[7:0];
            built[5] = HDR0 + HDR1 + LEN_BYTE_PLAIN + req_command[15:8]
                     + req_command[7:0];
            built[6] = TRL0;
            built[7] = TRL1;
            built_size = SIZE_PLAIN;
         end
         OP_VALUE: begin
            built[2] = LEN_BYTE_VALUE;
            built[3] = req_command[15:8];
            built[4] = req_command[7:0];
            built[5] = req_value;
            built[6] = HDR0 + HDR1 + LEN_BYTE_VALUE + req_command[15:8]
                     + req_command[7:0] + req_value;
            built[7] = TRL0;
            built[8] = TRL1;
            built_size = SIZE_VALUE;
         end
         OP_DRIVE: begin
            built[2]  = LEN_BYTE_DRIVE;
            built[3]  = DRIVE_CMD[15:8];
            built[4]  = DRIVE_CMD[7:0];
            built[5]  = left_lo;
            built[6]  = left_hi;
            built[7]  = right_lo;
            built[8]  = right_hi;
            built[9]  = HDR0 + HDR1 + LEN_BYTE_DRIVE + DRIVE_CMD[15:8]
                      + DRIVE_CMD[7:0] + left_lo + left_hi + right_lo + right_hi;
            built[10] = TRL0;
            built[11] = TRL1;
            built_size = SIZE_DRIVE;
         end
         default: begin
            // Mode start: empty checksum range, so the checksum byte is zero
            built[2] = LEN_BYTE_START;
            built[3] = START_CMD[15:8];
            built[4] = START_CMD[7:0];
            built[5] = '0;
            built[6] = TRL0;
            built[7] = TRL1;
            built_size = SIZE_START;
         end
      endcase
   end

   // Load a new frame, or shift the current one down by a byte
   always_comb begin
      for (int i = 0; i < FRAME_MAX; i++) begin
         frame_in[i] = frame_ff[i];
      end
      rem_in  = rem_ff;
      busy_in = busy_ff;
      if (req_fire) begin
         for (int i = 0; i < FRAME_MAX; i++) begin
            frame_in[i] = built[i];
         end
         rem_in  = built_size;
         busy_in = 1'b1;
      end else if (advance) begin
         for (int i = 0; i < FRAME_MAX - 1; i++) begin
            frame_in[i] = frame_ff[i+1];
         end
         frame_in[FRAME_MAX-1] = '0;
         rem_in  = rem_ff - COUNT_BITS'(1);
         busy_in = !last_byte;
      end
   end

   // Output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rem_ff       <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         rem_ff       <= rem_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      for (int i = 0; i < FRAME_MAX; i++) begin
         frame_ff[i] <= frame_in[i];
      end
      if (advance) begin
         rsp_tx_byte_ff <= frame_ff[0];
         rsp_last_ff    <= last_byte;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_tx_byte = rsp_tx_byte_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

/* sim/tb_top.sv */
// Self-checking bench for the serial command frame builder: random requests, byte-level checks.
`timescale 1ns / 1ps

module tb_top;
   import scfb_pkg::*;

   localparam int CLOCK_HALF_NS = 6;
   localparam int RESET_CYCLES  = 11;
   localparam int HOLD_CYCLES   = 150;
   localparam int DRAIN_CYCLES  = 20;
   // Timeout for a hung run, set well above the slowest legal run.
   localparam longint TIMEOUT_NS = 64'd3_000_000;

   // One expected frame byte with its position, for readable mismatch lines
   typedef struct {
      frame_byte_type tx_byte;
      logic           last;
      int             frame_no;
      int             pos;
   } expected_byte_type;

   // Frame predictor and store of frame bytes still owed by the block
   class frame_scoreboard;
      expected_byte_type owed_bytes[$];
      int fail_count;
      int frame_count;
      int byte_count;
      int op_count[4];

      task report(string msg);
         $display("MISMATCH: %s", msg);
         fail_count++;
      endtask

      // Build the frame for one accepted request and queue its bytes
      function void note_request(logic [1:0] op, logic [15:0] cmd, logic [7:0] val,
                                 logic signed [15:0] lp, logic signed [15:0] rp);
         frame_byte_type fb[FRAME_MAX];
         frame_byte_type sum;
         int body;
         expected_byte_type e;
         fb[0] = HDR0;
         fb[1] = HDR1;
         case (op)
            OP_PLAIN: begin
               fb[2] = LEN_BYTE_PLAIN;
               fb[3] = cmd[15:8];
               fb[4] = cmd[7:0];
               body = 5;
            end
            OP_VALUE: begin
               fb[2] = LEN_BYTE_VALUE;
               fb[3] = cmd[15:8];
               fb[4] = cmd[7:0];
               fb[5] = val;
               body = 6;
            end
            OP_DRIVE: begin
               fb[2] = LEN_BYTE_DRIVE;
               fb[3] = DRIVE_CMD[15:8];
               fb[4] = DRIVE_CMD[7:0];
               fb[5] = lp[7:0];
               fb[6] = lp[15:8];
               fb[7] = rp[7:0];
               fb[8] = rp[15:8];
               body = 9;
            end
            default: begin
               fb[2] = LEN_BYTE_START;
               fb[3] = START_CMD[15:8];
               fb[4] = START_CMD[7:0];
               body = 5;
            end
         endcase
         // Mode start sends a zero checksum; the others sum everything before it
         sum = 8'h00;
         if (op != OP_START) begin
            for (int i = 0; i < body; i++) sum = sum + fb[i];
         end
         fb[body]     = sum;
         fb[body + 1] = TRL0;
         fb[body + 2] = TRL1;
         for (int k = 0; k < body + 3; k++) begin
            e.tx_byte  = fb[k];
            e.last     = (k == body + 2);
            e.frame_no = frame_count;
            e.pos      = k;
            owed_bytes.push_back(e);
         end
         frame_count++;
         op_count[op]++;
      endfunction

      // Compare one rsp transfer with the oldest owed byte
      task check_byte(frame_byte_type got_byte, logic got_last);
         expected_byte_type e;
         if (owed_bytes.size() == 0) begin
            report($sformatf("rsp transfer 0x%02h last=%0b with no byte owed",
                             got_byte, got_last));
         end else begin
            e = owed_bytes.pop_front();
            byte_count++;
            if (got_byte !== e.tx_byte)
               report($sformatf("frame %0d byte %0d: tx_byte 0x%02h, want 0x%02h",
                                e.frame_no, e.pos, got_byte, e.tx_byte));
            if (got_last !== e.last)
               report($sformatf("frame %0d byte %0d: last %0b, want %0b",
                                e.frame_no, e.pos, got_last, e.last));
         end
      endtask

      function int outstanding();
         return owed_bytes.size();
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [1:0]               req_operation;
   logic [15:0]              req_command;
   logic [7:0]               req_value;
   logic signed [15:0]       req_left_pwm;
   logic signed [15:0]       req_right_pwm;
   logic                     rsp_valid;
   logic                     rsp_ready;
   frame_byte_type           rsp_tx_byte;
   logic                     rsp_last;

   frame_scoreboard sb;
   bit tx_idle_on;
   bit rx_idle_on;
   bit hold_off_request;

   serial_command_frame_builder dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_command   (req_command),
      .req_value     (req_value),
      .req_left_pwm  (req_left_pwm),
      .req_right_pwm (req_right_pwm),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_tx_byte   (rsp_tx_byte),
      .rsp_last      (rsp_last)
   );

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #(CLOCK_HALF_NS) clock = ~clock;
   end

   // Watch both channels; a transfer is a valid/ready pair at the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(req_operation, req_command, req_value,
                            req_left_pwm, req_right_pwm);
         if (rsp_valid && rsp_ready)
            sb.check_byte(rsp_tx_byte, rsp_last);
      end
   end

   // Receiver: random stall bursts, plus one long hold-off on request
   initial begin
      int gap_left;
      int hold_left;
      gap_left  = 0;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_ready <= 1'b0;
         end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(1, 5) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offer one request and hold it until the transfer
   task automatic send_request(logic [1:0] op, logic [15:0] cmd, logic [7:0] val,
                               logic signed [15:0] lp, logic signed [15:0] rp);
      int gap;
      if (tx_idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_command   <= cmd;
      req_value     <= val;
      req_left_pwm  <= lp;
      req_right_pwm <= rp;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drive speeds with a bias toward the range ends and minus one
   function automatic logic signed [15:0] pick_pwm();
      case ($urandom_range(0, 7))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'shFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic send_random(int count);
      for (int i = 0; i < count; i++)
         send_request(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                      8'($urandom_range(0, 255)), pick_pwm(), pick_pwm());
   endtask

   task automatic wait_drained();
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // Stimulus and end of run
   initial begin
      sb = new();
      tx_idle_on       = 1'b0;
      rx_idle_on       = 1'b0;
      hold_off_request = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_operation    = OP_PLAIN;
      req_command      = 16'h0000;
      req_value        = 8'h00;
      req_left_pwm     = 16'sh0000;
      req_right_pwm    = 16'sh0000;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: every operation, field extremes, ignored fields loaded
      send_request(OP_PLAIN, 16'h0000, 8'h00, 16'sh0000, 16'sh0000);
      send_request(OP_PLAIN, 16'hFFFF, 8'hFF, 16'sh7FFF, 16'sh8000);
      send_request(OP_PLAIN, 16'hA55A, 8'h3C, 16'sh1234, 16'sh4321);
      send_request(OP_VALUE, 16'h0000, 8'h00, 16'sh7FFF, 16'sh7FFF);
      send_request(OP_VALUE, 16'hFFFF, 8'hFF, 16'sh0000, 16'sh0000);
      send_request(OP_VALUE, 16'h5AA5, 8'h80, 16'sh8000, 16'shFFFF);
      send_request(OP_VALUE, 16'h0001, 8'h01, 16'sh0001, 16'sh0001);
      send_request(OP_DRIVE, 16'hFFFF, 8'hFF, 16'sh8000, 16'sh8000);
      send_request(OP_DRIVE, 16'h0000, 8'h00, 16'sh7FFF, 16'sh7FFF);
      send_request(OP_DRIVE, 16'h1234, 8'h55, 16'sh0000, 16'shFFFF);
      send_request(OP_DRIVE, 16'hBEEF, 8'hAA, 16'shFFFF, 16'sh0000);
      send_request(OP_DRIVE, 16'h0018, 8'h00, 16'sh0001, 16'sh8000);
      send_request(OP_DRIVE, 16'h0000, 8'h00, 16'sh8000, 16'sh7FFF);
      send_request(OP_START, 16'h0000, 8'h00, 16'sh0000, 16'sh0000);
      send_request(OP_START, 16'hFFFF, 8'hFF, 16'sh7FFF, 16'sh8000);
      send_request(OP_START, 16'hC3C3, 8'h5A, 16'shFFFF, 16'shFFFF);
      send_request(OP_PLAIN, 16'h0016, 8'h00, 16'sh0000, 16'sh0000);
      send_request(OP_VALUE, 16'h0018, 8'hFF, 16'sh0000, 16'sh0000);
      send_request(OP_PLAIN, 16'h00FF, 8'h00, 16'sh0000, 16'sh0000);
      send_request(OP_PLAIN, 16'hFF00, 8'h00, 16'sh0000, 16'sh0000);

      // Random with idling on both sides
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      send_random(120);

      // Hold the receiver off while requests keep coming, then pause to drain
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      hold_off_request = 1'b1;
      send_random(20);
      req_valid <= 1'b0;
      wait_drained();

      // Random with idling on one side at a time
      tx_idle_on = 1'b1;
      send_random(60);
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b1;
      send_random(60);

      // Back-to-back, no idling anywhere
      rx_idle_on = 1'b0;
      send_random(90);
      req_valid <= 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d requests (plain %0d, value %0d, drive %0d, start %0d),",
               sb.frame_count, sb.op_count[OP_PLAIN], sb.op_count[OP_VALUE],
               sb.op_count[OP_DRIVE], sb.op_count[OP_START]);
      $display("summary: %0d frame bytes checked, %0d mismatches",
               sb.byte_count, sb.fail_count);
      if (sb.fail_count == 0 && sb.outstanding() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #(TIMEOUT_NS);
      $display("timeout: %0d frame bytes still owed", sb.outstanding());
      $display("tb: failure");
      $finish;
   end

endmodule
